// File: design/bstf_pkg.sv
// Shared constants, types and helpers of the byte-stuffing transmit framer.
// No dependencies; every other design file but bstf_ram refers to this package by scope.
`timescale 1ns / 1ps
`default_nettype none

package bstf_pkg;

   // Ring store geometry
   localparam int STORE_DEPTH = 1024;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int WAIT_W      = 11;

   // Up to four stored bytes per request: flag, escape, byte, flag
   localparam int SLOT_N = 4;
   localparam int LEFT_W = 3;

   // Line codes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   // Request modes
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_DRAIN  = 1'b1;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [CNT_W-1:0] cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WRITE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic              byte_valid;
      logic [7:0]        line_byte;
      logic              frame_end;
      logic              frame_ok;
      logic [WAIT_W-1:0] waiting_count;
   } rsp_type;

   typedef struct packed {
      logic       wr_en;
      logic       rd_en;
      ptr_type    addr;
      logic [7:0] wr_data;
   } mem_req_type;

   // Step one entry around the ring
   function automatic ptr_type ring_next(ptr_type p);
      return (p == PTR_W'(STORE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Advance a ring pointer by a small count (at most SLOT_N)
   function automatic ptr_type ring_add(ptr_type p, logic [LEFT_W-1:0] n);
      logic [PTR_W:0] s;
      s = {1'b0, p} + (PTR_W + 1)'(n);
      if (s >= (PTR_W + 1)'(STORE_DEPTH)) begin
         s = s - (PTR_W + 1)'(STORE_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   // Committed count as shown on the response, kept to the field width
   function automatic logic [WAIT_W-1:0] wait_view(cnt_type c);
      logic [CNT_W+WAIT_W-1:0] e;
      e = {{WAIT_W{1'b0}}, c};
      return e[WAIT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: design/bstf_if.sv
// Request and response channel interfaces of the framer (valid/ready).
// Depends on bstf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bstf_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, mode, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, mode, data_byte, first_byte, last_byte, output ready);
endinterface

interface bstf_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       byte_valid;
   logic [7:0]                 line_byte;
   logic                       frame_end;
   logic                       frame_ok;
   logic [bstf_pkg::WAIT_W-1:0] waiting_count;

   modport source (output valid, byte_valid, line_byte, frame_end, frame_ok, waiting_count,
                   input ready);
   modport sink   (input valid, byte_valid, line_byte, frame_end, frame_ok, waiting_count,
                   output ready);
endinterface

`default_nettype wire

// File: design/bstf_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bstf_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: design/bstf_ctrl.sv
// Framer sequencer: ring pointers, fill counts, stuffing and store access.
// Depends on bstf_pkg and bstf_req_if; drives the store through mem_req_type.
`timescale 1ns / 1ps
`default_nettype none

module bstf_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   bstf_req_if.sink               req_ch,
   input  wire logic              out_free,
   input  wire logic [7:0]        rd_data,
   output bstf_pkg::mem_req_type  mem_req,
   output logic                   res_load,
   output bstf_pkg::rsp_type      res
);

   bstf_pkg::state_type state_ff, state_in;

   bstf_pkg::ptr_type rp_ff, rp_in;       // next committed byte to send
   bstf_pkg::ptr_type cp_ff, cp_in;       // end of committed bytes
   bstf_pkg::ptr_type wp_ff, wp_in;       // next write slot of the open frame
   bstf_pkg::ptr_type waddr_ff, waddr_in; // store address of the byte being written
   bstf_pkg::cnt_type committed_ff, committed_in;
   bstf_pkg::cnt_type wc_ff, wc_in;
   logic              ovf_ff, ovf_in;

   logic [7:0]                  slot_ff [bstf_pkg::SLOT_N];
   logic [7:0]                  slot_in [bstf_pkg::SLOT_N];
   logic [bstf_pkg::LEFT_W-1:0] left_ff, left_in;
   bstf_pkg::rsp_type           res_ff, res_in;

   logic acc;

   // Append evaluation
   logic                        is_open;
   logic                        restart;
   logic                        stuff;
   logic [bstf_pkg::LEFT_W-1:0] need;
   logic [bstf_pkg::LEFT_W-1:0] n_put;
   bstf_pkg::ptr_type           base_ptr;
   bstf_pkg::cnt_type           base_wc;
   logic                        base_ovf;
   logic [bstf_pkg::CNT_W+1:0]  total;
   logic                        fits;
   logic                        new_ovf;
   logic [7:0]                  seq [bstf_pkg::SLOT_N];
   logic [1:0]                  k;

   assign acc = req_ch.valid && req_ch.ready;

   // Fit test and stuffed byte sequence for an append request
   always_comb begin
      is_open  = (wc_ff != '0) || ovf_ff;
      stuff    = (req_ch.data_byte == bstf_pkg::FLAG_BYTE) ||
                 (req_ch.data_byte == bstf_pkg::ESC_BYTE);
      restart  = req_ch.first_byte || !is_open;
      base_ptr = restart ? cp_ff : wp_ff;
      base_wc  = restart ? '0 : wc_ff;
      base_ovf = restart ? 1'b0 : ovf_ff;
      need     = (stuff ? 3'd2 : 3'd1) + (restart ? 3'd1 : 3'd0) +
                 (req_ch.last_byte ? 3'd1 : 3'd0);
      total    = (bstf_pkg::CNT_W + 2)'(committed_ff) + (bstf_pkg::CNT_W + 2)'(base_wc) +
                 (bstf_pkg::CNT_W + 2)'(need);
      fits     = !base_ovf && (total <= (bstf_pkg::CNT_W + 2)'(bstf_pkg::STORE_DEPTH));
      new_ovf  = base_ovf || !fits;
      n_put    = fits ? need : '0;

      for (int i = 0; i < bstf_pkg::SLOT_N; i++) begin
         seq[i] = bstf_pkg::FLAG_BYTE;
      end
      k = '0;
      if (restart) begin
         seq[k] = bstf_pkg::FLAG_BYTE;
         k      = k + 2'd1;
      end
      if (stuff) begin
         seq[k]          = bstf_pkg::ESC_BYTE;
         seq[2'(k + 1)]  = req_ch.data_byte ^ bstf_pkg::ESC_XOR;
         k               = k + 2'd2;
      end else begin
         seq[k] = req_ch.data_byte;
         k      = k + 2'd1;
      end
      if (req_ch.last_byte) begin
         seq[k] = bstf_pkg::FLAG_BYTE;
      end
   end

   // Pointer, count and pending-response updates
   always_comb begin
      rp_in        = rp_ff;
      cp_in        = cp_ff;
      wp_in        = wp_ff;
      waddr_in     = waddr_ff;
      committed_in = committed_ff;
      wc_in        = wc_ff;
      ovf_in       = ovf_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      for (int i = 0; i < bstf_pkg::SLOT_N; i++) begin
         slot_in[i] = slot_ff[i];
      end

      unique case (state_ff)
         bstf_pkg::ST_IDLE: begin
            if (acc) begin
               res_in.line_byte = '0;
               if (req_ch.mode == bstf_pkg::MODE_DRAIN) begin
                  res_in.byte_valid = (committed_ff != '0);
                  res_in.frame_end  = 1'b0;
                  res_in.frame_ok   = 1'b0;
                  if (committed_ff != '0) begin
                     rp_in        = bstf_pkg::ring_next(rp_ff);
                     committed_in = committed_ff - 1'b1;
                  end
               end else begin
                  wp_in    = bstf_pkg::ring_add(base_ptr, n_put);
                  wc_in    = bstf_pkg::CNT_W'(base_wc + bstf_pkg::CNT_W'(n_put));
                  ovf_in   = new_ovf;
                  waddr_in = base_ptr;
                  left_in  = n_put;
                  for (int i = 0; i < bstf_pkg::SLOT_N; i++) begin
                     slot_in[i] = seq[i];
                  end
                  res_in.byte_valid = 1'b0;
                  res_in.frame_end  = req_ch.last_byte;
                  res_in.frame_ok   = 1'b0;
                  // Frame close: commit, or roll the whole frame back
                  if (req_ch.last_byte) begin
                     if (new_ovf) begin
                        wp_in  = cp_ff;
                        wc_in  = '0;
                        ovf_in = 1'b0;
                     end else begin
                        cp_in             = wp_in;
                        committed_in      = bstf_pkg::CNT_W'(committed_ff + wc_in);
                        wc_in             = '0;
                        res_in.frame_ok   = 1'b1;
                     end
                  end
               end
               res_in.waiting_count = bstf_pkg::wait_view(committed_in);
            end
         end
         bstf_pkg::ST_WRITE: begin
            waddr_in = bstf_pkg::ring_next(waddr_ff);
            left_in  = left_ff - 1'b1;
            for (int i = 0; i < bstf_pkg::SLOT_N - 1; i++) begin
               slot_in[i] = slot_ff[i+1];
            end
         end
         bstf_pkg::ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bstf_pkg::ST_IDLE: begin
            if (acc) begin
               if (req_ch.mode == bstf_pkg::MODE_DRAIN || n_put == '0) begin
                  state_in = bstf_pkg::ST_RESP;
               end else begin
                  state_in = bstf_pkg::ST_WRITE;
               end
            end
         end
         bstf_pkg::ST_WRITE: begin
            if (left_ff == bstf_pkg::LEFT_W'(1)) begin
               state_in = bstf_pkg::ST_RESP;
            end
         end
         bstf_pkg::ST_RESP: begin
            if (out_free) begin
               state_in = bstf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bstf_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs: handshake, store access, finished response
   always_comb begin
      req_ch.ready    = (state_ff == bstf_pkg::ST_IDLE);
      mem_req.wr_en   = (state_ff == bstf_pkg::ST_WRITE);
      mem_req.rd_en   = acc && (req_ch.mode == bstf_pkg::MODE_DRAIN) && (committed_ff != '0);
      mem_req.addr    = (state_ff == bstf_pkg::ST_WRITE) ? waddr_ff : rp_ff;
      mem_req.wr_data = slot_ff[0];
      res_load        = (state_ff == bstf_pkg::ST_RESP) && out_free;
      res             = res_ff;
      res.line_byte   = res_ff.byte_valid ? rd_data : 8'h00;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bstf_pkg::ST_IDLE;
         rp_ff        <= '0;
         cp_ff        <= '0;
         wp_ff        <= '0;
         committed_ff <= '0;
         wc_ff        <= '0;
         ovf_ff       <= 1'b0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         cp_ff        <= cp_in;
         wp_ff        <= wp_in;
         committed_ff <= committed_in;
         wc_ff        <= wc_in;
         ovf_ff       <= ovf_in;
         left_ff      <= left_in;
      end
   end

   // Payload holding registers
   always_ff @(posedge clock) begin
      waddr_ff <= waddr_in;
      res_ff   <= res_in;
      for (int i = 0; i < bstf_pkg::SLOT_N; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

`default_nettype wire

// File: design/byte_stuffing_tx_framer_unit.sv
// Top level of the byte-stuffing transmit framer: sequencer, ring store, output register.
// Depends on bstf_pkg, bstf_if, bstf_ram and bstf_ctrl.
//
//   channel   dir  fields                                               accepted when
//   req_ch    in   mode, data_byte, first_byte, last_byte              valid && ready
//   rsp_ch    out  byte_valid, line_byte, frame_end, frame_ok,
//                  waiting_count                                        valid && ready
//
// One request at a time. A drain request reads the store as it is accepted, then
// responds; an append request writes n = 0..4 bytes through the single store port,
// one per cycle, then responds. A finished response waits in the output register,
// so the next request is taken while it is still held.
// Synchronous reset clears pointers and counts; the store itself needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffing_tx_framer_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   bstf_req_if.sink   req_ch,
   bstf_rsp_if.source rsp_ch
);

   bstf_pkg::mem_req_type mem_req;
   logic [7:0]            rd_data;
   logic                  res_load;
   bstf_pkg::rsp_type     res;
   logic                  out_free;

   logic                  rsp_valid_ff, rsp_valid_in;
   bstf_pkg::rsp_type     rsp_data_ff;

   bstf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .out_free (out_free),
      .rd_data  (rd_data),
      .mem_req  (mem_req),
      .res_load (res_load),
      .res      (res)
   );

   bstf_ram #(
      .DEPTH (bstf_pkg::STORE_DEPTH),
      .WIDTH (8)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .rd_en   (mem_req.rd_en),
      .addr    (mem_req.addr),
      .wr_data (mem_req.wr_data),
      .rd_data (rd_data)
   );

   // Output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.byte_valid    = rsp_data_ff.byte_valid;
   assign rsp_ch.line_byte     = rsp_data_ff.line_byte;
   assign rsp_ch.frame_end     = rsp_data_ff.frame_end;
   assign rsp_ch.frame_ok      = rsp_data_ff.frame_ok;
   assign rsp_ch.waiting_count = rsp_data_ff.waiting_count;

endmodule

`default_nettype wire

// File: design/bstf_checker.sv
// Port-level checks of the framer top level, attached by bind.
// Depends on bstf_pkg and byte_stuffing_tx_framer_unit.
`timescale 1ns / 1ps
`default_nettype none

module bstf_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_ready,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_ready,
   input wire logic                        rsp_byte_valid,
   input wire logic [7:0]                  rsp_line_byte,
   input wire logic                        rsp_frame_end,
   input wire logic                        rsp_frame_ok,
   input wire logic [bstf_pkg::WAIT_W-1:0] rsp_waiting_count
);

   // Stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_byte) &&
         $stable(rsp_frame_end) && $stable(rsp_frame_ok) && $stable(rsp_waiting_count))
      else $error("response changed while stalled");

   // One request in flight: no accept on the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one still in work");

   // A drained byte never carries frame status, and frame_ok needs frame_end
   a_kind_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_byte_valid && rsp_frame_end) && (!rsp_frame_ok || rsp_frame_end))
      else $error("response mixes drain and frame status");

   // No byte means a zero line byte
   a_empty_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_line_byte == 8'h00)
      else $error("line byte set without a byte");

   // Waiting count never exceeds the store
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_waiting_count) <= 32'(bstf_pkg::STORE_DEPTH))
      else $error("waiting count beyond store depth");

endmodule

bind byte_stuffing_tx_framer_unit bstf_checker u_bstf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_byte_valid    (rsp_ch.byte_valid),
   .rsp_line_byte     (rsp_ch.line_byte),
   .rsp_frame_end     (rsp_ch.frame_end),
   .rsp_frame_ok      (rsp_ch.frame_ok),
   .rsp_waiting_count (rsp_ch.waiting_count)
);

`default_nettype wire

// File: test/tb_top.sv
// Self-checking bench for byte_stuffing_tx_framer_unit: HDLC framing, escaping, overflow discard.
// Depends on bstf_pkg, bstf_req_if / bstf_rsp_if and the framer RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_REQUESTS = 1850;
   localparam int SETTLE_CYCLES   = 16;

   typedef struct {
      logic       mode;
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } line_request_type;

   logic clock;
   logic reset;

   bstf_req_if req_if ();
   bstf_rsp_if rsp_if ();

   byte_stuffing_tx_framer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   line_request_type  request_backlog[$];
   bstf_pkg::rsp_type due_responses[$];
   line_request_type  on_wire;
   int                errors;

   // Shadow of the framer: ring contents, pointers, fill counts
   logic [7:0] ring_bytes [bstf_pkg::STORE_DEPTH];
   int         send_ptr, sealed_ptr, build_ptr;
   int         sealed_cnt, build_cnt;
   bit         build_dropped;

   // Run statistics
   int frames_sealed, frames_dropped, bytes_sent, escapes_seen, peak_waiting;

   // Clock and reset
   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------
   // Framer prediction
   // ---------------------------------------------------------------
   function automatic int ring_fwd(int p);
      return (p + 1) % bstf_pkg::STORE_DEPTH;
   endfunction

   function automatic void put_line_byte(logic [7:0] b);
      ring_bytes[build_ptr] = b;
      build_ptr = ring_fwd(build_ptr);
      build_cnt++;
   endfunction

   // Throw away the frame under construction
   function automatic void reopen_build();
      build_ptr     = sealed_ptr;
      build_cnt     = 0;
      build_dropped = 1'b0;
   endfunction

   function automatic bstf_pkg::rsp_type stuff_or_drain(line_request_type r);
      bstf_pkg::rsp_type o;
      bit                was_open, escape;
      int                room;
      o = '0;
      if (r.mode == bstf_pkg::MODE_DRAIN) begin
         if (sealed_cnt > 0) begin
            o.byte_valid = 1'b1;
            o.line_byte  = ring_bytes[send_ptr];
            send_ptr     = ring_fwd(send_ptr);
            sealed_cnt--;
            bytes_sent++;
         end
      end else begin
         was_open = (build_cnt != 0) || build_dropped;
         escape   = (r.data_byte == bstf_pkg::FLAG_BYTE) ||
                    (r.data_byte == bstf_pkg::ESC_BYTE);
         if (escape) escapes_seen++;
         // a first mark, or no open frame, starts over
         if (r.first_byte || !was_open) begin
            reopen_build();
            was_open = 1'b0;
         end
         room = (escape ? 2 : 1) + (was_open ? 0 : 1) + (r.last_byte ? 1 : 0);
         if (!build_dropped) begin
            if (sealed_cnt + build_cnt + room > bstf_pkg::STORE_DEPTH) begin
               build_dropped = 1'b1;
            end else begin
               if (!was_open) put_line_byte(bstf_pkg::FLAG_BYTE);
               if (escape) begin
                  put_line_byte(bstf_pkg::ESC_BYTE);
                  put_line_byte(r.data_byte ^ bstf_pkg::ESC_XOR);
               end else begin
                  put_line_byte(r.data_byte);
               end
               if (r.last_byte) put_line_byte(bstf_pkg::FLAG_BYTE);
            end
         end
         // close: commit or discard
         if (r.last_byte) begin
            o.frame_end = 1'b1;
            if (build_dropped) begin
               reopen_build();
               frames_dropped++;
            end else begin
               sealed_ptr  = build_ptr;
               sealed_cnt += build_cnt;
               build_cnt   = 0;
               o.frame_ok  = 1'b1;
               frames_sealed++;
            end
         end
      end
      if (sealed_cnt > peak_waiting) peak_waiting = sealed_cnt;
      o.waiting_count = bstf_pkg::WAIT_W'(sealed_cnt);
      return o;
   endfunction

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   task automatic queue_item(logic mode, logic [7:0] data, logic first, logic last);
      line_request_type r;
      r.mode       = mode;
      r.data_byte  = data;
      r.first_byte = first;
      r.last_byte  = last;
      request_backlog.push_back(r);
   endtask

   // payload fields of a drain are don't-care, so randomize them
   task automatic queue_drain();
      queue_item(bstf_pkg::MODE_DRAIN, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
   endtask

   function automatic logic [7:0] pick_payload(int stuff_pct);
      if ($urandom_range(99) < stuff_pct)
         return $urandom_range(1) ? bstf_pkg::FLAG_BYTE : bstf_pkg::ESC_BYTE;
      return 8'($urandom_range(255));
   endfunction

   task automatic queue_directed();
      queue_drain();                                                  // nothing committed yet
      queue_item(bstf_pkg::MODE_APPEND, 8'h00, 1'b1, 1'b1);           // one-byte frame
      queue_item(bstf_pkg::MODE_APPEND, bstf_pkg::FLAG_BYTE, 1'b1, 1'b0); // both escaped codes
      queue_item(bstf_pkg::MODE_APPEND, bstf_pkg::ESC_BYTE, 1'b0, 1'b0);
      queue_item(bstf_pkg::MODE_APPEND, 8'hFF, 1'b0, 1'b0);
      queue_item(bstf_pkg::MODE_APPEND, 8'h5E, 1'b0, 1'b1);           // looks escaped, is not
      queue_item(bstf_pkg::MODE_APPEND, bstf_pkg::ESC_BYTE, 1'b1, 1'b1);
      queue_item(bstf_pkg::MODE_APPEND, 8'h11, 1'b0, 1'b0);           // opens with no first mark
      queue_item(bstf_pkg::MODE_APPEND, 8'h22, 1'b0, 1'b1);
      queue_item(bstf_pkg::MODE_APPEND, 8'h33, 1'b1, 1'b0);           // dropped by the next first
      queue_item(bstf_pkg::MODE_APPEND, 8'h44, 1'b1, 1'b0);
      queue_item(bstf_pkg::MODE_APPEND, bstf_pkg::FLAG_BYTE, 1'b0, 1'b1);
      queue_item(bstf_pkg::MODE_APPEND, 8'hA5, 1'b0, 1'b1);           // lone last mark
      repeat (10) queue_drain();
   endtask

   // Phases: fill the ring hard, drain it dry, then mixed traffic
   task automatic queue_random(int total);
      int phase_kind, phase_left, drain_pct, stuff_pct, len, cut;
      bit skip_first, drop_last;
      phase_kind = 0;
      phase_left = 0;
      drain_pct  = 0;
      stuff_pct  = 0;
      total += request_backlog.size();
      while (request_backlog.size() < total) begin
         if (phase_left <= 0) begin
            case (phase_kind)
               0: begin
                  drain_pct  = 2;
                  phase_left = $urandom_range(500, 800);
               end
               1: begin
                  drain_pct  = 95;
                  phase_left = $urandom_range(300, 600);
               end
               default: begin
                  drain_pct  = 40;
                  phase_left = $urandom_range(150, 300);
               end
            endcase
            phase_kind = (phase_kind + 1) % 3;
            stuff_pct  = $urandom_range(5, 60);
         end
         if ($urandom_range(99) < drain_pct) begin
            len = $urandom_range(1, 4);
            repeat (len) queue_drain();
         end else begin
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 12);
            // a few broken frames: no first mark, or never closed
            cut        = $urandom_range(99);
            skip_first = (cut < 4);
            drop_last  = (cut >= 4) && (cut < 8);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(99) < drain_pct / 4) queue_drain();
               queue_item(bstf_pkg::MODE_APPEND, pick_payload(stuff_pct),
                          (i == 0) && !skip_first, (i == len - 1) && !drop_last);
            end
         end
         phase_left -= len;
      end
   endtask

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps
   // ---------------------------------------------------------------
   int burst_left, gap_left;

   initial begin
      req_if.valid      = 1'b0;
      req_if.mode       = bstf_pkg::MODE_APPEND;
      req_if.data_byte  = 8'h00;
      req_if.first_byte = 1'b0;
      req_if.last_byte  = 1'b0;
      rsp_if.ready      = 1'b0;
   end

   always @(posedge clock) begin
      logic hold;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            due_responses.push_back(stuff_or_drain(on_wire));
         end
         hold = req_if.valid && !req_if.ready;
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               on_wire = request_backlog.pop_front();
               req_if.valid      <= 1'b1;
               req_if.mode       <= on_wire.mode;
               req_if.data_byte  <= on_wire.data_byte;
               req_if.first_byte <= on_wire.first_byte;
               req_if.last_byte  <= on_wire.last_byte;
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
                                                        : $urandom_range(1, 40);
                  gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // Response monitor and stall pattern
   // ---------------------------------------------------------------
   int stall_kind, stall_left, stall_tick;

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         errors++;
         $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      bstf_pkg::rsp_type want;
      logic              take;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_responses.size() == 0) begin
               errors++;
               $display("%0t ns: response with none expected, line_byte 0x%0h", $time,
                        rsp_if.line_byte);
            end else begin
               want = due_responses.pop_front();
               check_field("byte_valid", want.byte_valid, rsp_if.byte_valid);
               check_field("line_byte", want.line_byte, rsp_if.line_byte);
               check_field("frame_end", want.frame_end, rsp_if.frame_end);
               check_field("frame_ok", want.frame_ok, rsp_if.frame_ok);
               check_field("waiting_count", want.waiting_count, rsp_if.waiting_count);
            end
         end
         // receiver mood: always ready, coin flip, mostly stalled, long stalls
         if (stall_left == 0) begin
            stall_kind = $urandom_range(3);
            stall_left = $urandom_range(10, 60);
         end
         stall_left--;
         stall_tick++;
         case (stall_kind)
            0:       take = 1'b1;
            1:       take = 1'($urandom_range(1));
            2:       take = ($urandom_range(3) == 0);
            default: take = (stall_tick % 16) >= 12;
         endcase
         rsp_if.ready <= take;
      end
   end

   // ---------------------------------------------------------------
   // Sequence and end of run
   // ---------------------------------------------------------------
   initial begin
      errors = 0;
      frames_sealed = 0; frames_dropped = 0; bytes_sent = 0;
      escapes_seen = 0; peak_waiting = 0;
      send_ptr = 0; sealed_ptr = 0; build_ptr = 0;
      sealed_cnt = 0; build_cnt = 0; build_dropped = 1'b0;
      burst_left = 0; gap_left = 0;
      stall_kind = 0; stall_left = 0; stall_tick = 0;
      queue_directed();
      queue_random(RANDOM_REQUESTS);
      while (reset) @(posedge clock);
      while (request_backlog.size() != 0 || req_if.valid) @(posedge clock);
      while (due_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Frames: %0d committed, %0d discarded on overflow; %0d escaped payload bytes",
               frames_sealed, frames_dropped, escapes_seen);
      $display("Line bytes sent: %0d; deepest backlog %0d of %0d", bytes_sent, peak_waiting,
               bstf_pkg::STORE_DEPTH);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Timeout with %0d requests pending, %0d responses due",
               request_backlog.size(), due_responses.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
